### src/bts_pkg.sv
package bts_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int FRAC_BITS   = 16;
    localparam int ONE_FX      = 1 << FRAC_BITS;

    localparam int SIZE_W      = 9;
    localparam int XW          = $clog2(MAX_WIDTH);
    localparam int YW          = $clog2(MAX_HEIGHT);
    localparam int FW          = FRAC_BITS + 1;
    localparam int CW          = 24;
    localparam int ADDR_W      = 16;
    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam int DATA_W      = 64;
    localparam int CH_W        = 16;

    localparam int MID_DEPTH   = 4;
    localparam int MID_PTR_W   = $clog2(MID_DEPTH);
    localparam int OUT_DEPTH   = 4;
    localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
    localparam int CNT_W       = $clog2(OUT_DEPTH + 1);

    localparam int CFG_IDX_W   = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COMP_COUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXEL_FMT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_S      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_T      = 3'd5;

    typedef enum logic {
        REQ_WRITE  = 1'b0,
        REQ_SAMPLE = 1'b1
    } req_kind_t;

    typedef enum logic {
        WRAP_CLAMP  = 1'b0,
        WRAP_REPEAT = 1'b1
    } wrap_t;

    typedef enum logic {
        FMT_U8  = 1'b0,
        FMT_U16 = 1'b1
    } fmt_t;

    typedef struct packed {
        req_kind_t               req_type;
        logic [ADDR_W-1:0]       texel_addr;
        logic [DATA_W-1:0]       texel_data;
        logic signed [CW-1:0]    coord_s;
        logic signed [CW-1:0]    coord_t;
    } req_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
    } res_t;

    typedef struct packed {
        logic [SIZE_W-1:0] tex_width;
        logic [SIZE_W-1:0] tex_height;
        logic [2:0]        component_count;
        fmt_t              texel_format;
        wrap_t             wrap_s_mode;
        wrap_t             wrap_t_mode;
    } cfg_t;

    typedef struct packed {
        req_kind_t                    kind;
        logic [ADDR_W-1:0]            waddr;
        logic [DATA_W-1:0]            wdata;
        logic [3:0][ADDR_W-1:0]       raddr;
        logic [FRAC_BITS-1:0]         fx;
        logic [FRAC_BITS-1:0]         fy;
    } mid_t;

    typedef struct packed {
        logic [CNT_W-1:0] out_cnt;
        logic [1:0]       inflight;
        logic [CNT_W-1:0] mid_cnt;
    } stat_t;

endpackage

### src/bts_ram.sv
module bts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a <= mem_reg[raddr_a];
        rdata_b <= mem_reg[raddr_b];
    end

endmodule

### src/bts_front.sv
module bts_front import bts_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  push,
    output logic  full,
    input  req_t  req,
    output logic  q_push,
    input  logic  q_full,
    output mid_t  q_entry
);

    function automatic logic [FW-1:0] wrap_coord(input logic signed [CW-1:0] c, input wrap_t m);
        logic signed [CW-1:0] one_s;
        logic [CW-1:0]        neg;
        logic [FW-1:0]        res;
        one_s = CW'(ONE_FX);
        neg   = -c;
        if (m == WRAP_CLAMP)
        begin
            if (c < 0)
                res = '0;
            else if (c > one_s)
                res = FW'(ONE_FX);
            else
                res = c[FW-1:0];
        end
        else
        begin
            if (c < 0)
                res = FW'(ONE_FX) - {1'b0, neg[FRAC_BITS-1:0]};
            else if (c > one_s)
                res = {1'b0, c[FRAC_BITS-1:0]};
            else
                res = c[FW-1:0];
        end
        return res;
    endfunction

    function automatic logic [SIZE_W-1:0] limit_size(input logic [SIZE_W-1:0] v, input int mx);
        logic [SIZE_W-1:0] res;
        if (v == '0)
            res = SIZE_W'(1);
        else if (v > SIZE_W'(mx))
            res = SIZE_W'(mx);
        else
            res = v;
        return res;
    endfunction

    logic [SIZE_W-1:0] w_lim, h_lim;
    logic [XW-1:0]     wm1;
    logic [YW-1:0]     hm1;
    logic              en;

    logic                   s0_v_reg;
    req_kind_t              s0_kind_reg;
    logic [ADDR_W-1:0]      s0_waddr_reg;
    logic [DATA_W-1:0]      s0_wdata_reg;
    logic [FW+XW-1:0]       s0_px_reg;
    logic [FW+YW-1:0]       s0_py_reg;

    logic                   s1_v_reg;
    req_kind_t              s1_kind_reg;
    logic [ADDR_W-1:0]      s1_waddr_reg;
    logic [DATA_W-1:0]      s1_wdata_reg;
    logic [XW-1:0]          s1_xl_reg, s1_xh_reg;
    logic [ADDR_W-1:0]      s1_ylw_reg, s1_yhw_reg;
    logic [FRAC_BITS-1:0]   s1_fx_reg, s1_fy_reg;

    logic [FW+XW-FRAC_BITS-1:0] lx_raw, hx_raw;
    logic [FW+YW-FRAC_BITS-1:0] ly_raw, hy_raw;
    logic [XW-1:0]              xl, xh;
    logic [YW-1:0]              yl, yh;

    assign w_lim = limit_size(cfg.tex_width, MAX_WIDTH);
    assign h_lim = limit_size(cfg.tex_height, MAX_HEIGHT);
    assign wm1   = XW'(w_lim - SIZE_W'(1));
    assign hm1   = YW'(h_lim - SIZE_W'(1));

    assign en     = !s1_v_reg || !q_full;
    assign full   = !en;
    assign q_push = s1_v_reg && !q_full;

    always_comb
    begin
        lx_raw = s0_px_reg[FW+XW-1:FRAC_BITS];
        hx_raw = lx_raw + (FW+XW-FRAC_BITS)'(|s0_px_reg[FRAC_BITS-1:0]);
        ly_raw = s0_py_reg[FW+YW-1:FRAC_BITS];
        hy_raw = ly_raw + (FW+YW-FRAC_BITS)'(|s0_py_reg[FRAC_BITS-1:0]);
        xl = (lx_raw > (FW+XW-FRAC_BITS)'(wm1)) ? wm1 : lx_raw[XW-1:0];
        xh = (hx_raw > (FW+XW-FRAC_BITS)'(wm1)) ? wm1 : hx_raw[XW-1:0];
        yl = (ly_raw > (FW+YW-FRAC_BITS)'(hm1)) ? hm1 : ly_raw[YW-1:0];
        yh = (hy_raw > (FW+YW-FRAC_BITS)'(hm1)) ? hm1 : hy_raw[YW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg <= 1'b0;
            s1_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_v_reg <= push;
            s1_v_reg <= s0_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_kind_reg  <= req.req_type;
            s0_waddr_reg <= req.texel_addr;
            s0_wdata_reg <= req.texel_data;
            s0_px_reg    <= wrap_coord(req.coord_s, cfg.wrap_s_mode) * wm1;
            s0_py_reg    <= wrap_coord(req.coord_t, cfg.wrap_t_mode) * hm1;

            s1_kind_reg  <= s0_kind_reg;
            s1_waddr_reg <= s0_waddr_reg;
            s1_wdata_reg <= s0_wdata_reg;
            s1_xl_reg    <= xl;
            s1_xh_reg    <= xh;
            s1_ylw_reg   <= ADDR_W'(yl * w_lim);
            s1_yhw_reg   <= ADDR_W'(yh * w_lim);
            s1_fx_reg    <= s0_px_reg[FRAC_BITS-1:0];
            s1_fy_reg    <= s0_py_reg[FRAC_BITS-1:0];
        end
    end

    always_comb
    begin
        q_entry.kind     = s1_kind_reg;
        q_entry.waddr    = s1_waddr_reg;
        q_entry.wdata    = s1_wdata_reg;
        q_entry.raddr[0] = ADDR_W'(s1_ylw_reg + ADDR_W'(s1_xl_reg));
        q_entry.raddr[1] = ADDR_W'(s1_ylw_reg + ADDR_W'(s1_xh_reg));
        q_entry.raddr[2] = ADDR_W'(s1_yhw_reg + ADDR_W'(s1_xl_reg));
        q_entry.raddr[3] = ADDR_W'(s1_yhw_reg + ADDR_W'(s1_xh_reg));
        q_entry.fx       = s1_fx_reg;
        q_entry.fy       = s1_fy_reg;
    end

endmodule

### src/bts_mid_fifo.sv
module bts_mid_fifo import bts_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  mid_t             push_entry,
    output logic             full,
    input  logic             pop,
    output mid_t             head,
    output logic             empty,
    output logic [CNT_W-1:0] count
);

    mid_t                 mem_reg [MID_DEPTH];
    logic [MID_PTR_W-1:0] wr_reg, rd_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(MID_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign count   = cnt_reg;
    assign head    = mem_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
                wr_reg <= wr_reg + MID_PTR_W'(1);
            if (do_pop)
                rd_reg <= rd_reg + MID_PTR_W'(1);
            cnt_reg <= cnt_reg + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= push_entry;
    end

endmodule

### src/bts_back.sv
module bts_back import bts_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  mid_t             head,
    input  logic             q_empty,
    output logic             q_pop,
    output logic             empty,
    input  logic             pop,
    output res_t             res,
    output logic [CNT_W-1:0] out_count,
    output logic [1:0]       inflight
);

    function automatic logic [3:0][CH_W-1:0] expand(input logic [DATA_W-1:0] d,
                                                    input fmt_t f, input logic [2:0] comps);
        logic [3:0][CH_W-1:0] c;
        logic [3:0][CH_W-1:0] ch;
        logic [CH_W-1:0]      v;
        for (int k = 0; k < 4; k++)
        begin
            v    = d[CH_W*k +: CH_W];
            c[k] = (f == FMT_U16) ? v : {v[7:0], v[7:0]};
        end
        if (comps <= 3'd2)
        begin
            ch[0] = c[0];
            ch[1] = c[0];
            ch[2] = c[0];
            ch[3] = (comps == 3'd2) ? c[1] : '1;
        end
        else
        begin
            ch[0] = c[0];
            ch[1] = c[1];
            ch[2] = c[2];
            ch[3] = (comps >= 3'd4) ? c[3] : '1;
        end
        return ch;
    endfunction

    function automatic logic [CH_W-1:0] blend(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b,
                                              input logic [FRAC_BITS-1:0] f);
        logic [FRAC_BITS:0]           onef;
        logic [CH_W+FRAC_BITS+1:0]    sum;
        onef = (FRAC_BITS+1)'(ONE_FX) - {1'b0, f};
        sum  = (CH_W+FRAC_BITS+2)'(a * onef) + (CH_W+FRAC_BITS+2)'(b * f)
             + (CH_W+FRAC_BITS+2)'(ONE_FX / 2);
        return sum[FRAC_BITS +: CH_W];
    endfunction

    logic                  issue_wr, issue_rd, credit;
    logic [DATA_W-1:0]     bl_d, br_d, tl_d, tr_d;
    logic [3:0][CH_W-1:0]  bl, br, tl, tr, bot, top;
    logic [3:0][CH_W-1:0]  bot_reg, top_reg;
    logic                  b1_v_reg, b2_v_reg;
    logic [FRAC_BITS-1:0]  b1_fx_reg, b1_fy_reg, b2_fy_reg;
    res_t                  y_res;

    res_t                  out_mem_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]  out_wr_reg, out_rd_reg;
    logic [CNT_W-1:0]      out_cnt_reg;
    logic                  out_pop;

    assign credit   = (CNT_W+1)'(out_cnt_reg) + (CNT_W+1)'(b1_v_reg) + (CNT_W+1)'(b2_v_reg)
                    < (CNT_W+1)'(OUT_DEPTH);
    assign issue_wr = !q_empty && (head.kind == REQ_WRITE);
    assign issue_rd = !q_empty && (head.kind == REQ_SAMPLE) && credit;
    assign q_pop    = issue_wr || issue_rd;

    bts_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_ram_lo (
        .clk     (clk),
        .we      (issue_wr),
        .waddr   (head.waddr),
        .wdata   (head.wdata),
        .raddr_a (head.raddr[0]),
        .raddr_b (head.raddr[1]),
        .rdata_a (bl_d),
        .rdata_b (br_d)
    );

    bts_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_ram_hi (
        .clk     (clk),
        .we      (issue_wr),
        .waddr   (head.waddr),
        .wdata   (head.wdata),
        .raddr_a (head.raddr[2]),
        .raddr_b (head.raddr[3]),
        .rdata_a (tl_d),
        .rdata_b (tr_d)
    );

    always_comb
    begin
        bl = expand(bl_d, cfg.texel_format, cfg.component_count);
        br = expand(br_d, cfg.texel_format, cfg.component_count);
        tl = expand(tl_d, cfg.texel_format, cfg.component_count);
        tr = expand(tr_d, cfg.texel_format, cfg.component_count);
        for (int k = 0; k < 4; k++)
        begin
            bot[k] = blend(bl[k], br[k], b1_fx_reg);
            top[k] = blend(tl[k], tr[k], b1_fx_reg);
        end
        y_res.red   = blend(bot_reg[0], top_reg[0], b2_fy_reg);
        y_res.green = blend(bot_reg[1], top_reg[1], b2_fy_reg);
        y_res.blue  = blend(bot_reg[2], top_reg[2], b2_fy_reg);
        y_res.alpha = blend(bot_reg[3], top_reg[3], b2_fy_reg);
    end

    assign empty     = (out_cnt_reg == '0);
    assign res       = out_mem_reg[out_rd_reg];
    assign out_pop   = pop && !empty;
    assign out_count = out_cnt_reg;
    assign inflight  = 2'(b1_v_reg) + 2'(b2_v_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_v_reg    <= 1'b0;
            b2_v_reg    <= 1'b0;
            out_wr_reg  <= '0;
            out_rd_reg  <= '0;
            out_cnt_reg <= '0;
        end
        else
        begin
            b1_v_reg <= issue_rd;
            b2_v_reg <= b1_v_reg;
            if (b2_v_reg)
                out_wr_reg <= out_wr_reg + OUT_PTR_W'(1);
            if (out_pop)
                out_rd_reg <= out_rd_reg + OUT_PTR_W'(1);
            out_cnt_reg <= out_cnt_reg + CNT_W'(b2_v_reg) - CNT_W'(out_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        b1_fx_reg <= head.fx;
        b1_fy_reg <= head.fy;
        bot_reg   <= bot;
        top_reg   <= top;
        b2_fy_reg <= b1_fy_reg;
        if (b2_v_reg)
            out_mem_reg[out_wr_reg] <= y_res;
    end

endmodule

### src/bilinear_texture_sampler.sv
// Bilinear texture sampler. One item, a texel write or a sample, is taken
// per clock while full is low. A front pipeline, registers s0 and s1,
// wraps the coordinates, scales them and forms the four corner addresses; a
// four-entry queue hands them to a back pipeline that reads the texture
// store and blends. The store is held twice, each copy with two read ports,
// so all four corners are read together and every write goes to both copies.
// A sample passes the front, queue, store read, blend and output registers;
// four results can wait on the output before the back stops taking samples.
// The store is not cleared at reset: read only texels that were written.
module bilinear_texture_sampler import bts_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data,
    input  logic                 push,
    output logic                 full,
    input  req_t                 req,
    output logic                 empty,
    input  logic                 pop,
    output res_t                 res
);

    cfg_t  cfg_reg;
    mid_t  q_entry, q_head;
    logic  q_push, q_full, q_pop, q_empty;
    stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tex_width       <= SIZE_W'(256);
            cfg_reg.tex_height      <= SIZE_W'(256);
            cfg_reg.component_count <= 3'd4;
            cfg_reg.texel_format    <= FMT_U8;
            cfg_reg.wrap_s_mode     <= WRAP_REPEAT;
            cfg_reg.wrap_t_mode     <= WRAP_REPEAT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TEX_WIDTH:  cfg_reg.tex_width       <= cfg_data;
                CFG_TEX_HEIGHT: cfg_reg.tex_height      <= cfg_data;
                CFG_COMP_COUNT: cfg_reg.component_count <= cfg_data[2:0];
                CFG_TEXEL_FMT:  cfg_reg.texel_format    <= fmt_t'(cfg_data[0]);
                CFG_WRAP_S:     cfg_reg.wrap_s_mode     <= wrap_t'(cfg_data[0]);
                CFG_WRAP_T:     cfg_reg.wrap_t_mode     <= wrap_t'(cfg_data[0]);
                default:        ;
            endcase
        end
    end

    bts_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .push    (push),
        .full    (full),
        .req     (req),
        .q_push  (q_push),
        .q_full  (q_full),
        .q_entry (q_entry)
    );

    bts_mid_fifo u_mid (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty),
        .count      (stat.mid_cnt)
    );

    bts_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .head      (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .empty     (empty),
        .pop       (pop),
        .res       (res),
        .out_count (stat.out_cnt),
        .inflight  (stat.inflight)
    );

    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        ((CNT_W+1)'(stat.out_cnt) + (CNT_W+1)'(stat.inflight)) <= (CNT_W+1)'(OUT_DEPTH))
        else $error("output queue overcommitted");

    a_mid_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.mid_cnt <= CNT_W'(MID_DEPTH))
        else $error("middle queue overflow");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> (empty && !full))
        else $error("not idle in reset");

    a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> (stat.mid_cnt == CNT_W'(MID_DEPTH)))
        else $error("input stalled with room in middle queue");

endmodule
